[rtl/lsd_pkg.sv]
package lsd_pkg;

    // Frame layout
    localparam int FRAME_NODES = 360;
    localparam int NODE_IDX_W  = 9;
    localparam int NODE_LAST   = 4;   // byte position that completes a node

    localparam logic [7:0] SYNC_BYTE  = 8'hA5;
    localparam logic [7:0] HEADER_TAG = 8'h81;

    typedef enum logic [1:0] {
        MODE_HUNT  = 2'd0,
        MODE_NODES = 2'd1,
        MODE_CHECK = 2'd2
    } lsd_mode_t;

    typedef struct packed {
        logic                  frame_done;
        logic                  frame_ok;
        logic [NODE_IDX_W-1:0] node_index;
        logic [7:0]            quality;
        logic [15:0]           angle_raw;
        logic [15:0]           distance_raw;
        logic [7:0]            speed_raw;
    } lsd_result_t;

endpackage

[rtl/lsd_if.sv]
interface lsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lsd_result_if;
    logic        valid;
    logic        ready;
    logic        frame_done;
    logic        frame_ok;
    logic [8:0]  node_index;
    logic [7:0]  quality;
    logic [15:0] angle_raw;
    logic [15:0] distance_raw;
    logic [7:0]  speed_raw;

    modport source (output valid, output frame_done, output frame_ok, output node_index,
                    output quality, output angle_raw, output distance_raw,
                    output speed_raw, input ready);
    modport sink   (input valid, input frame_done, input frame_ok, input node_index,
                    input quality, input angle_raw, input distance_raw,
                    input speed_raw, output ready);
endinterface

[rtl/lidar_scan_frame_deframer.sv]
// Pipeline: an accepted byte is held in the input register; the parser step then
// loads its result, if it yields one, into the result register.
// Throughput: one byte per cycle, sustained; a stalled result holds the pipe.
// Reset (rst_n, asynchronous, active low) returns the parser to header hunt
// with a cleared window, zero counters and zero latched speed; no beat is pending.
module lidar_scan_frame_deframer
    import lsd_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    lsd_byte_if.sink     rx,
    lsd_result_if.source res
);

    logic        in_vld_reg;
    logic [7:0]  in_byte_reg;
    logic        out_vld_reg;
    lsd_result_t out_data_reg;
    logic        advance;
    logic        step_vld;
    lsd_result_t step_res;

    // Step the parser only when the result slot is free or draining
    assign advance  = in_vld_reg && (!out_vld_reg || res.ready);
    assign rx.ready = !in_vld_reg || advance;

    // Hold the input beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_vld_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            in_byte_reg <= rx.rx_byte;
        end
    end

    lsd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .res_vld (step_vld),
        .res     (step_res)
    );

    // Load or drain the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= step_vld;
        end
        else if (res.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && step_vld)
        begin
            out_data_reg <= step_res;
        end
    end

    assign res.valid        = out_vld_reg;
    assign res.frame_done   = out_data_reg.frame_done;
    assign res.frame_ok     = out_data_reg.frame_ok;
    assign res.node_index   = out_data_reg.node_index;
    assign res.quality      = out_data_reg.quality;
    assign res.angle_raw    = out_data_reg.angle_raw;
    assign res.distance_raw = out_data_reg.distance_raw;
    assign res.speed_raw    = out_data_reg.speed_raw;

endmodule

[rtl/lsd_parser.sv]
module lsd_parser
    import lsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  rx_byte,
    output logic        res_vld,
    output lsd_result_t res
);

    lsd_mode_t                 mode_reg, mode_next;
    logic [47:0]               window_reg, window_next;
    logic [2:0]                bin_reg, bin_next;
    logic [NODE_IDX_W-1:0]     count_reg, count_next;
    logic [31:0]               nbytes_reg, nbytes_next;
    logic [7:0]                speed_reg, speed_next;
    logic [NODE_IDX_W:0]       count_inc;
    logic                      hdr_match;

    assign count_inc = {1'b0, count_reg} + (NODE_IDX_W+1)'(1);
    assign hdr_match = (window_reg[47:40] == SYNC_BYTE) && (rx_byte == HEADER_TAG);

    // Hold parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_HUNT;
            window_reg <= '0;
            bin_reg    <= '0;
            count_reg  <= '0;
            nbytes_reg <= '0;
            speed_reg  <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            window_reg <= window_next;
            bin_reg    <= bin_next;
            count_reg  <= count_next;
            nbytes_reg <= nbytes_next;
            speed_reg  <= speed_next;
        end
    end

    // Advance the parser by one byte
    always_comb
    begin
        mode_next   = mode_reg;
        window_next = window_reg;
        bin_next    = bin_reg;
        count_next  = count_reg;
        nbytes_next = nbytes_reg;
        speed_next  = speed_reg;
        res_vld     = 1'b0;
        res         = '0;
        if (step)
        begin
            case (mode_reg)
                MODE_NODES:
                begin
                    if (bin_reg < 3'(NODE_LAST))
                    begin
                        nbytes_next[8*bin_reg[1:0] +: 8] = rx_byte;
                        bin_next = bin_reg + 3'd1;
                    end
                    else
                    begin
                        // Fifth byte completes the node
                        res_vld          = 1'b1;
                        res.node_index   = count_reg;
                        res.quality      = nbytes_reg[7:0];
                        res.angle_raw    = nbytes_reg[23:8];
                        res.distance_raw = {rx_byte, nbytes_reg[31:24]};
                        res.speed_raw    = speed_reg;
                        bin_next         = '0;
                        nbytes_next      = '0;
                        if (count_inc >= (NODE_IDX_W+1)'(FRAME_NODES))
                        begin
                            mode_next = MODE_CHECK;
                        end
                        count_next = count_inc[NODE_IDX_W-1:0];
                    end
                end
                MODE_CHECK:
                begin
                    // Report frame status, then feed the byte to a cleared hunt window
                    res_vld        = 1'b1;
                    res.frame_done = 1'b1;
                    res.frame_ok   = (rx_byte == SYNC_BYTE);
                    res.speed_raw  = speed_reg;
                    mode_next      = MODE_HUNT;
                    bin_next       = '0;
                    count_next     = '0;
                    nbytes_next    = '0;
                    window_next    = {40'd0, rx_byte};
                end
                default:
                begin
                    mode_next = MODE_HUNT;
                    if (hdr_match)
                    begin
                        speed_next  = window_reg[39:32];
                        mode_next   = MODE_NODES;
                        bin_next    = '0;
                        count_next  = '0;
                        nbytes_next = '0;
                        window_next = '0;
                    end
                    else
                    begin
                        window_next = {window_reg[39:0], rx_byte};
                    end
                end
            endcase
        end
    end

    a_node_pos: assert property (@(posedge clk) disable iff (!rst_n)
        step && res_vld && !res.frame_done |->
            mode_reg == MODE_NODES && bin_reg == 3'(NODE_LAST))
        else $error("node emitted before its fifth byte");

    a_bin_range: assert property (@(posedge clk) disable iff (!rst_n)
        bin_reg <= 3'(NODE_LAST))
        else $error("byte position past node end");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_NODES |->
            {1'b0, count_reg} < (NODE_IDX_W+1)'(FRAME_NODES))
        else $error("node count past frame size while collecting");

    a_header_lock: assert property (@(posedge clk) disable iff (!rst_n)
        step && mode_reg != MODE_NODES && mode_reg != MODE_CHECK && hdr_match |=>
            mode_reg == MODE_NODES && count_reg == '0 && bin_reg == '0
            && window_reg == '0)
        else $error("header match did not start a clean frame");

endmodule

[dv/lsd_deframe_checker.sv]
module lsd_deframe_checker
    import lsd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    lsd_byte_if   rx,
    lsd_result_if res,
    output int    fail_count,
    output int    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Predicted parser state
    lsd_mode_t   mode;
    logic [47:0] hunt_window;
    logic [2:0]  node_pos;
    logic [8:0]  node_cnt;
    logic [31:0] node_acc;
    logic [7:0]  speed_latch;

    // Predicted node and status beats, oldest first
    lsd_result_t frame_results_q[$];

    // Shift one byte through the header window, or lock onto a header
    function automatic void hunt_header(input logic [7:0] b);
        if (hunt_window[47:40] == SYNC_BYTE && b == HEADER_TAG) begin
            speed_latch = hunt_window[39:32];
            mode        = MODE_NODES;
            node_pos    = '0;
            node_cnt    = '0;
            node_acc    = '0;
            hunt_window = '0;
        end
        else begin
            hunt_window = {hunt_window[39:0], b};
        end
    endfunction

    // Advance the parser by one byte; return 1 when a result beat is due
    function automatic bit deframe_byte(input logic [7:0] b, output lsd_result_t r);
        logic [9:0] next_cnt;
        bit         emitted;
        emitted = 1'b0;
        r       = '0;
        if (mode == MODE_NODES) begin
            if (node_pos < NODE_LAST) begin
                node_acc = node_acc | (32'(b) << (8 * node_pos));
                node_pos = node_pos + 3'd1;
            end
            else begin
                r.quality      = node_acc[7:0];
                r.angle_raw    = node_acc[23:8];
                r.distance_raw = {b, node_acc[31:24]};
                r.node_index   = node_cnt;
                r.speed_raw    = speed_latch;
                next_cnt       = {1'b0, node_cnt} + 10'd1;
                node_pos       = '0;
                node_acc       = '0;
                if (next_cnt >= FRAME_NODES)
                    mode = MODE_CHECK;
                node_cnt = next_cnt[8:0];
                emitted  = 1'b1;
            end
        end
        else if (mode == MODE_CHECK) begin
            // Status beat, then the same byte restarts the header hunt
            r.frame_done = 1'b1;
            r.frame_ok   = (b == SYNC_BYTE);
            r.speed_raw  = speed_latch;
            mode         = MODE_HUNT;
            node_pos     = '0;
            node_cnt     = '0;
            node_acc     = '0;
            hunt_window  = '0;
            hunt_header(b);
            emitted = 1'b1;
        end
        else begin
            mode = MODE_HUNT;
            hunt_header(b);
        end
        return emitted;
    endfunction

    function automatic void check_field(input string name, input int unsigned want_val,
                                        input int unsigned got_val);
        if (want_val != got_val) begin
            $error("%s: expected %0h, got %0h", name, want_val, got_val);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        lsd_result_t want;
        if (!rst_n) begin
            mode        = MODE_HUNT;
            hunt_window = '0;
            node_pos    = '0;
            node_cnt    = '0;
            node_acc    = '0;
            speed_latch = '0;
            frame_results_q.delete();
            pending = 0;
        end
        else begin
            // Predict from each accepted byte beat
            if (rx.valid && rx.ready) begin
                if (deframe_byte(rx.rx_byte, want))
                    frame_results_q.push_back(want);
            end
            // Compare each accepted result beat with the oldest prediction
            if (res.valid && res.ready) begin
                if (frame_results_q.size() == 0) begin
                    $error("result beat with no prediction pending (frame_done %0b, index %0d)",
                           res.frame_done, res.node_index);
                    fail_count++;
                end
                else begin
                    want = frame_results_q.pop_front();
                    check_field("frame_done", want.frame_done, res.frame_done);
                    check_field("frame_ok", want.frame_ok, res.frame_ok);
                    check_field("node_index", want.node_index, res.node_index);
                    check_field("quality", want.quality, res.quality);
                    check_field("angle_raw", want.angle_raw, res.angle_raw);
                    check_field("distance_raw", want.distance_raw, res.distance_raw);
                    check_field("speed_raw", want.speed_raw, res.speed_raw);
                end
            end
            pending = frame_results_q.size();
        end
    end

endmodule

[dv/tb_top.sv]
module tb_top;
    import lsd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BYTE_GOAL    = 1300;
    localparam int STEADY_START = 300;
    localparam int STEADY_STOP  = 800;
    localparam int DRAIN_CYCLES = 10;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   sent_total = 0;
    bit   steady     = 1'b0;

    lsd_byte_if   rx_if ();
    lsd_result_if res_if ();

    lidar_scan_frame_deframer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .res   (res_if)
    );

    lsd_deframe_checker deframe_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx_if),
        .res        (res_if),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Stall the result side at random, except in the steady stretch
    always @(posedge clk)
    begin
        res_if.ready <= steady || ($urandom_range(0, 99) >= 7);
    end

    // Uniform byte with extra weight on all-zeros and all-ones
    function automatic logic [7:0] rand_byte();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Drive one byte beat, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b);
        steady = (sent_total >= STEADY_START && sent_total < STEADY_STOP);
        while (!steady && $urandom_range(0, 99) < 7) begin
            rx_if.valid <= 1'b0;
            @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_if.ready);
        sent_total++;
    endtask

    // Send n nodes; with trap set, the last node opens with a sync byte
    task automatic send_nodes(input int n, input bit trap);
        for (int i = 0; i < n; i++) begin
            for (int k = 0; k <= NODE_LAST; k++) begin
                if (trap && i == n - 1 && k == 0)
                    send_byte(SYNC_BYTE);
                else
                    send_byte(rand_byte());
            end
        end
    endtask

    // Send a whole frame: header, nodes and check byte
    task automatic send_frame(input bit skip_sync, input bit trap, output bit chain);
        logic [7:0] b;
        if (!skip_sync)
            send_byte(SYNC_BYTE);
        send_byte(rand_byte());
        repeat (4) send_byte(rand_byte());
        send_byte(HEADER_TAG);
        send_nodes(FRAME_NODES, trap);
        chain = 1'b0;
        if (!trap && $urandom_range(0, 3) < 2) begin
            // Good check byte; half the time it also opens the next header
            send_byte(SYNC_BYTE);
            chain = $urandom_range(0, 1);
        end
        else begin
            b = rand_byte();
            if (b == SYNC_BYTE)
                b = 8'h5A;
            send_byte(b);
            // Tag that would match a stale window holding the last node's sync byte
            if (trap)
                send_byte(HEADER_TAG);
        end
    endtask

    initial
    begin
        #(5_000_000);
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        bit          chain;
        int unsigned pick;
        int unsigned gap;
        logic [7:0]  tag;

        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Stray zero byte and a sync followed too soon by a tag
        send_byte(8'h00);
        send_byte(SYNC_BYTE);
        send_byte(HEADER_TAG);
        // Header with top speed
        send_byte(SYNC_BYTE);
        send_byte(8'hFF);
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(8'h56);
        send_byte(8'h78);
        send_byte(HEADER_TAG);
        // All-ones node, all-zeros node, then a node with distinct bytes
        repeat (5) send_byte(8'hFF);
        repeat (5) send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'h34);
        send_byte(8'h12);
        send_byte(8'h78);
        send_byte(8'h56);
        // Finish the frame with a bad check byte
        send_nodes(FRAME_NODES - 3, 1'b0);
        send_byte(8'h00);

        // Mostly well-formed frames, mixed with noise and broken headers
        chain = 1'b0;
        while (sent_total < BYTE_GOAL || chain) begin
            if (chain) begin
                send_frame(1'b1, 1'b0, chain);
            end
            else begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    send_frame(1'b0, pick < 8, chain);
                end
                else if (pick < 80) begin
                    repeat ($urandom_range(10, 80)) begin
                        pick = $urandom_range(0, 99);
                        if (pick < 20)
                            send_byte(SYNC_BYTE);
                        else if (pick < 35)
                            send_byte(HEADER_TAG);
                        else
                            send_byte(rand_byte());
                    end
                end
                else begin
                    // Header with a wrong tag, or with a tag one byte early or late
                    gap = $urandom_range(4, 6);
                    tag = HEADER_TAG;
                    if (gap == 5) begin
                        tag = rand_byte();
                        if (tag == HEADER_TAG)
                            tag = 8'h18;
                    end
                    send_byte(SYNC_BYTE);
                    repeat (gap) send_byte(rand_byte());
                    send_byte(tag);
                end
            end
        end
        rx_if.valid <= 1'b0;

        // Drain outstanding results, then allow for the pipeline depth
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
rtl/lsd_pkg.sv
rtl/lsd_if.sv
rtl/lsd_parser.sv
rtl/lidar_scan_frame_deframer.sv
dv/lsd_deframe_checker.sv
dv/tb_top.sv
